// ===== rtl/bdq_pkg.sv =====
// ============================================================================
// bdq_pkg: shared types and constants for the bounded deque
// Field widths, operation codes, sequencer states and the result record that
// passes from the sequencer to the output register.
// ============================================================================
package bdq_pkg;

  localparam int FUNC_W      = 3;
  localparam int VAL_W       = 32;
  localparam int OCC_W       = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [FUNC_W-1:0] FN_PUSH_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_HEAD  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_TAIL  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SEARCH    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_WAIT,
    ST_SEARCH,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [OCC_W-1:0]        occupancy;
    logic signed [VAL_W-1:0] popped_value;
    logic                    ok;
  } res_t;

endpackage

// ===== rtl/bounded_deque_with_search.sv =====
// ============================================================================
// bounded_deque_with_search: bounded double-ended queue with value search
// A ring of DEPTH signed 32-bit slots with head pointer and element count,
// serving push/pop at either end and a linear membership search.
// ============================================================================
//
//  channel  direction  payload
//  -------  ---------  ------------------------------------------------------
//  in_      slave      tuser: func; tdata: item_value
//  out_     master     tdata: ok, popped_value, occupancy (one per request)
//
//  Pushes and failed operations pass through EXEC to DONE; pops add a
//  POP_WAIT state for the registered RAM read. A search walks at most
//  occupancy entries with the single comparator, one entry per cycle through
//  the RAM's one read port. One request is in work at a time; the next is
//  taken once its result sits in the output register. Reset is synchronous
//  and clears the head pointer and count; slot contents are not cleared.
//
module bounded_deque_with_search #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] item_value
  input  logic [bdq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [2:0] func
  input  logic [bdq_pkg::FUNC_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] ok, [32:1] popped_value, [37:33] occupancy, [39:38] zero
  output logic [bdq_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int AW = $clog2(DEPTH);

  logic                       res_valid, res_ready;
  bdq_pkg::res_t              res;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [bdq_pkg::VAL_W-1:0]  ram_wdata, ram_rdata;

  logic                       out_valid_r;
  bdq_pkg::res_t              out_data_r;

  bdq_ram #(
    .WIDTH(bdq_pkg::VAL_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_value (in_tdata[bdq_pkg::VAL_W-1:0]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = bdq_pkg::OUT_TDATA_W'(out_data_r);

endmodule

// ===== rtl/bdq_ram.sv =====
// ============================================================================
// bdq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bdq_ctrl.sv =====
// ============================================================================
// bdq_ctrl: deque sequencer
// Holds the head pointer and element count, drives the slot RAM and walks
// the stored entries one per cycle through a single comparator on a search.
// ============================================================================
module bdq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bdq_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [bdq_pkg::VAL_W-1:0]    in_value,
  output logic                                res_valid,
  input  logic                                res_ready,
  output bdq_pkg::res_t                       res,
  output logic                                ram_we,
  output logic [$clog2(DEPTH)-1:0]            ram_waddr,
  output logic [bdq_pkg::VAL_W-1:0]           ram_wdata,
  output logic [$clog2(DEPTH)-1:0]            ram_raddr,
  input  logic [bdq_pkg::VAL_W-1:0]           ram_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  bdq_pkg::ctrl_state_t             state_r, state_nxt;
  logic [bdq_pkg::FUNC_W-1:0]       func_r, func_nxt;
  logic signed [bdq_pkg::VAL_W-1:0] value_r, value_nxt;
  logic [AW-1:0]                    head_r, head_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic                             ok_r, ok_nxt;
  logic signed [bdq_pkg::VAL_W-1:0] popped_r, popped_nxt;
  logic [AW-1:0]                    scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0]                    left_r, left_nxt;

  logic full, empty;

  // Position base + off in the ring; off never exceeds DEPTH.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    value_r    <= value_nxt;
    ok_r       <= ok_nxt;
    popped_r   <= popped_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    left_r     <= left_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    value_nxt    = value_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    ok_nxt       = ok_r;
    popped_nxt   = popped_r;
    scan_ptr_nxt = scan_ptr_r;
    left_nxt     = left_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = head_r;
    ram_wdata    = value_r;
    ram_raddr    = scan_ptr_r;

    case (state_r)
      bdq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt  = in_func;
          value_nxt = in_value;
          state_nxt = bdq_pkg::ST_EXEC;
        end
      end

      bdq_pkg::ST_EXEC: begin
        ok_nxt     = 1'b0;
        popped_nxt = '0;
        state_nxt  = bdq_pkg::ST_DONE;
        case (func_r)
          bdq_pkg::FN_PUSH_HEAD: begin
            if (!full) begin
              head_nxt  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
              ram_we    = 1'b1;
              ram_waddr = head_nxt;
              count_nxt = count_r + CW'(1);
              ok_nxt    = 1'b1;
            end
          end
          bdq_pkg::FN_PUSH_TAIL: begin
            if (!full) begin
              ram_we    = 1'b1;
              ram_waddr = ring_add(head_r, count_r);
              count_nxt = count_r + CW'(1);
              ok_nxt    = 1'b1;
            end
          end
          bdq_pkg::FN_POP_HEAD: begin
            if (!empty) begin
              ram_raddr = head_r;
              head_nxt  = ring_inc(head_r);
              count_nxt = count_r - CW'(1);
              state_nxt = bdq_pkg::ST_POP_WAIT;
            end
          end
          bdq_pkg::FN_POP_TAIL: begin
            if (!empty) begin
              ram_raddr = ring_add(head_r, count_r - CW'(1));
              count_nxt = count_r - CW'(1);
              state_nxt = bdq_pkg::ST_POP_WAIT;
            end
          end
          bdq_pkg::FN_SEARCH: begin
            if (!empty) begin
              // Start the scan at the head; the RAM returns its data in the following cycle.
              ram_raddr    = head_r;
              scan_ptr_nxt = ring_inc(head_r);
              left_nxt     = count_r;
              state_nxt    = bdq_pkg::ST_SEARCH;
            end
          end
          default: begin
          end
        endcase
      end

      bdq_pkg::ST_POP_WAIT: begin
        ok_nxt     = 1'b1;
        popped_nxt = ram_rdata;
        state_nxt  = bdq_pkg::ST_DONE;
      end

      bdq_pkg::ST_SEARCH: begin
        // The entry read last cycle is compared while the next one is fetched.
        if (ram_rdata == value_r) begin
          ok_nxt    = 1'b1;
          state_nxt = bdq_pkg::ST_DONE;
        end else if (left_r == CW'(1)) begin
          state_nxt = bdq_pkg::ST_DONE;
        end else begin
          ram_raddr    = scan_ptr_r;
          scan_ptr_nxt = ring_inc(scan_ptr_r);
          left_nxt     = left_r - CW'(1);
        end
      end

      bdq_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = bdq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  assign res.ok           = ok_r;
  assign res.popped_value = popped_r;
  assign res.occupancy    = bdq_pkg::OCC_W'(count_r);

endmodule

// ===== rtl/bdq_checker.sv =====
// ============================================================================
// bdq_checker: port-level checks for the bounded deque
// Watches the stream ports of the top level and flags broken results.
// ============================================================================
module bdq_checker #(
  parameter int DEPTH = 16
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bdq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A held result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Only one request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // A failed request must report a zero popped value.
  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == '0)
    else $error("popped value on failed request");

  // Occupancy never exceeds the store size.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (DEPTH > 31) || (out_tdata[37:33] <= 5'(DEPTH)))
    else $error("occupancy beyond depth");

endmodule

bind bounded_deque_with_search bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bounded_deque_with_search
// Drives push, pop and search requests through the input stream. Each result
// is checked field by field against its typed row or a ring-buffer predictor
// kept in step with every accepted request. Both stream sides idle at random,
// the receiver once holds off for long, and the sender once drains the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH         = 16;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int IDLE_LIMIT    = 5000;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 40;

  // Selector values that the block does not decode.
  localparam logic [bdq_pkg::FUNC_W-1:0] FN_RSVD_5 = 3'd5;
  localparam logic [bdq_pkg::FUNC_W-1:0] FN_RSVD_6 = 3'd6;
  localparam logic [bdq_pkg::FUNC_W-1:0] FN_RSVD_7 = 3'd7;

  typedef struct packed {
    logic                      ok;
    logic [bdq_pkg::VAL_W-1:0] popped;
    logic [bdq_pkg::OCC_W-1:0] occ;
  } deque_result_t;

  typedef struct packed {
    logic [bdq_pkg::FUNC_W-1:0] fn;
    logic [bdq_pkg::VAL_W-1:0]  val;
    logic                       typed;
    deque_result_t              res;
  } directed_row_t;

  localparam int N_DIRECTED = 27;

  // Rows with typed set carry their expected result; the rest use the predictor.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{bdq_pkg::FN_POP_HEAD,  32'h0000_0000, 1'b1, '{1'b0, 32'h0, 5'd0}},
    '{bdq_pkg::FN_POP_TAIL,  32'h0000_0000, 1'b1, '{1'b0, 32'h0, 5'd0}},
    '{bdq_pkg::FN_SEARCH,    32'h0000_0000, 1'b1, '{1'b0, 32'h0, 5'd0}},
    '{FN_RSVD_7,             32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 5'd0}},
    '{bdq_pkg::FN_PUSH_HEAD, 32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h0, 5'd1}},
    '{bdq_pkg::FN_PUSH_TAIL, 32'h8000_0000, 1'b1, '{1'b1, 32'h0, 5'd2}},
    '{bdq_pkg::FN_SEARCH,    32'h8000_0000, 1'b1, '{1'b1, 32'h0, 5'd2}},
    '{bdq_pkg::FN_PUSH_HEAD, 32'hFFFF_FFFF, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_TAIL, 32'h0000_0000, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_HEAD, 32'h0000_0001, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_TAIL, 32'hFFFF_FFFE, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_HEAD, 32'hAAAA_AAAA, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_TAIL, 32'h5555_5555, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_HEAD, 32'h8000_0001, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_TAIL, 32'h7FFF_FFFE, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_HEAD, 32'h0000_FFFF, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_TAIL, 32'hFFFF_0000, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_HEAD, 32'h0F0F_0F0F, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_TAIL, 32'hF0F0_F0F0, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_HEAD, 32'h0001_0000, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_TAIL, 32'hC3C3_3C3C, 1'b0, '0},
    '{bdq_pkg::FN_PUSH_HEAD, 32'h1234_5678, 1'b1, '{1'b0, 32'h0, 5'd16}},
    '{FN_RSVD_6,             32'h0000_0000, 1'b1, '{1'b0, 32'h0, 5'd16}},
    '{bdq_pkg::FN_SEARCH,    32'hC3C3_3C3C, 1'b0, '0},
    '{bdq_pkg::FN_SEARCH,    32'h1234_5678, 1'b0, '0},
    '{bdq_pkg::FN_POP_HEAD,  32'h0000_0000, 1'b0, '0},
    '{bdq_pkg::FN_POP_TAIL,  32'hFFFF_FFFF, 1'b0, '0}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [bdq_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [bdq_pkg::FUNC_W-1:0]      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [bdq_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Predictor state.
  logic [bdq_pkg::VAL_W-1:0] model_slots [DEPTH];
  logic [3:0]                model_head;
  int unsigned               model_count;

  deque_result_t pending_results [$];
  int unsigned   error_count;
  int unsigned   results_seen;

  bounded_deque_with_search #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic deque_result_t apply_deque_op(input logic [bdq_pkg::FUNC_W-1:0] fn,
                                                   input logic [bdq_pkg::VAL_W-1:0] val);
    deque_result_t r;
    logic [3:0]    idx;
    r = '0;
    case (fn)
      bdq_pkg::FN_PUSH_HEAD: begin
        if (model_count < DEPTH) begin
          model_head              = model_head - 4'd1;
          model_slots[model_head] = val;
          model_count++;
          r.ok = 1'b1;
        end
      end
      bdq_pkg::FN_PUSH_TAIL: begin
        if (model_count < DEPTH) begin
          idx              = model_head + 4'(model_count);
          model_slots[idx] = val;
          model_count++;
          r.ok = 1'b1;
        end
      end
      bdq_pkg::FN_POP_HEAD: begin
        if (model_count > 0) begin
          r.popped   = model_slots[model_head];
          model_head = model_head + 4'd1;
          model_count--;
          r.ok = 1'b1;
        end
      end
      bdq_pkg::FN_POP_TAIL: begin
        if (model_count > 0) begin
          idx      = model_head + 4'(model_count - 1);
          r.popped = model_slots[idx];
          model_count--;
          r.ok = 1'b1;
        end
      end
      bdq_pkg::FN_SEARCH: begin
        for (int i = 0; i < model_count; i++) begin
          if (model_slots[model_head + 4'(i)] == val) r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.occ = bdq_pkg::OCC_W'(model_count);
    return r;
  endfunction

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 13));
  endfunction

  task automatic report_mismatch(input string what, input logic [bdq_pkg::VAL_W-1:0] got,
                                 input logic [bdq_pkg::VAL_W-1:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_tvalid still high, so back-to-back requests never lower it.
  task automatic send_request(input logic [bdq_pkg::FUNC_W-1:0] fn,
                              input logic [bdq_pkg::VAL_W-1:0] val,
                              input bit typed, input deque_result_t typed_res,
                              input bit calm);
    int            gap;
    deque_result_t predicted;
    gap = draw_gap(calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_deque_op(fn, val);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Receiver: random stalls, quiet stretches, and one long hold-off.
  initial begin : result_receiver
    int            gap;
    bit            hold_done;
    deque_result_t want;
    logic [1:0]    pad;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap((results_seen / 170) % 4 == 1);
      if (!hold_done && results_seen == 500) begin
        gap       = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_seen++;
      pad = out_tdata[39:38];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.ok)
          report_mismatch("ok", bdq_pkg::VAL_W'(out_tdata[0]), bdq_pkg::VAL_W'(want.ok));
        if (out_tdata[32:1] !== want.popped)
          report_mismatch("popped_value", out_tdata[32:1], want.popped);
        if (out_tdata[37:33] !== want.occ)
          report_mismatch("occupancy", bdq_pkg::VAL_W'(out_tdata[37:33]),
                          bdq_pkg::VAL_W'(want.occ));
        if (pad !== 2'b00) report_mismatch("tdata padding", bdq_pkg::VAL_W'(pad), '0);
      end
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no transfer on either side.
  initial begin : idle_watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", idle_cycles);
          $display("** bounded_deque_with_search: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [bdq_pkg::FUNC_W-1:0] fn;
    logic [bdq_pkg::VAL_W-1:0]  val;
    int unsigned                pick;
    int unsigned                mode;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    rst_n        = 1'b0;
    model_head   = '0;
    model_count  = 0;
    error_count  = 0;
    results_seen = 0;
    foreach (model_slots[i]) model_slots[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].fn, directed_rows[i].val, directed_rows[i].typed,
                   directed_rows[i].res, 1'b0);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Once, let every outstanding result come back before going on.
      if (n == 1000) begin
        in_tvalid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      // Segments lean towards filling, draining or a balanced mix so that
      // both the full and the empty boundaries are visited with wrap-around.
      mode = (n / 64) % 3;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        fn = bdq_pkg::FUNC_W'($urandom_range(FN_RSVD_5, FN_RSVD_7));
      end else if (pick < 24) begin
        fn = bdq_pkg::FN_SEARCH;
      end else if (mode == 0) begin
        fn = ($urandom_range(0, 99) < 75)
             ? bdq_pkg::FUNC_W'($urandom_range(bdq_pkg::FN_PUSH_HEAD, bdq_pkg::FN_PUSH_TAIL))
             : bdq_pkg::FUNC_W'($urandom_range(bdq_pkg::FN_POP_HEAD, bdq_pkg::FN_POP_TAIL));
      end else if (mode == 1) begin
        fn = ($urandom_range(0, 99) < 75)
             ? bdq_pkg::FUNC_W'($urandom_range(bdq_pkg::FN_POP_HEAD, bdq_pkg::FN_POP_TAIL))
             : bdq_pkg::FUNC_W'($urandom_range(bdq_pkg::FN_PUSH_HEAD, bdq_pkg::FN_PUSH_TAIL));
      end else begin
        fn = bdq_pkg::FUNC_W'($urandom_range(bdq_pkg::FN_PUSH_HEAD, bdq_pkg::FN_POP_TAIL));
      end
      case ($urandom_range(0, 7))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'hFFFF_FFFF;
        3:       val = 32'(signed'($urandom_range(0, 8)) - 4);
        default: val = $urandom();
      endcase
      // Most searches look for a value that is actually stored.
      if (fn == bdq_pkg::FN_SEARCH && model_count > 0 && $urandom_range(0, 99) < 60) begin
        val = model_slots[model_head + 4'($urandom_range(0, model_count - 1))];
      end
      send_request(fn, val, 1'b0, '0, (n / 150) % 4 == 3);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** bounded_deque_with_search: PASSED **");
    end else begin
      $display("** bounded_deque_with_search: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque_with_search.sv
rtl/bdq_checker.sv
tb/sv/tb_top.sv
